// ===== rtl/core/sdpg_pkg.sv =====
// Shared types, constants and register indexes of the step/dir pulse generator.
package sdpg_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int SPEED_W           = 24;
   localparam int CFG_W             = 10;
   localparam int POS_W             = 32;
   localparam int CSR_IDX_W         = 1;

   // Interval numerator: 1e6 us/s times 16 for the four speed fraction bits.
   localparam logic [SPEED_W-1:0] INTERVAL_NUM = 24'd16000000;

   localparam logic [CFG_W-1:0] PULSE_HIGH_RESET = 10'd2;
   localparam logic [CFG_W-1:0] DIR_SETUP_RESET  = 10'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PULSE_HIGH = 1'b0,
      REG_DIR_SETUP  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIR,
      ST_DIV,
      ST_SCHED,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/sdpg_ifs.sv =====
// Request and response channel interfaces of the step/dir pulse generator.
interface sdpg_req_if;
   logic                           valid;
   logic                           ready;
   logic                           enable_in;
   logic                           direction_in;
   logic [sdpg_pkg::SPEED_W-1:0]   speed_q4;

   modport source (output valid, output enable_in, output direction_in, output speed_q4,
                   input ready);
   modport sink (input valid, input enable_in, input direction_in, input speed_q4,
                 output ready);
endinterface

interface sdpg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                step_level;
   logic                                dir_level;
   logic                                step_done;
   logic signed [sdpg_pkg::POS_W-1:0]   position;

   modport source (output valid, output step_level, output dir_level, output step_done,
                   output position, input ready);
   modport sink (input valid, input step_level, input dir_level, input step_done,
                 input position, output ready);
endinterface

// ===== rtl/core/sdpg_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module sdpg_divider #(
   parameter int Width = sdpg_pkg::SPEED_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [Width-1:0] dividend,
   input  logic [Width-1:0] divisor,
   output logic             done,
   output logic [Width-1:0] quotient
);

   localparam int CntW = $clog2(Width + 1);
   localparam logic [CntW-1:0] LastCnt = CntW'(Width - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [Width-1:0] rem_ff, rem_in;
   logic [Width-1:0] quo_ff, quo_in;
   logic [Width-1:0] dsr_ff, dsr_in;
   logic [Width:0]   shifted;
   logic [Width:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[Width-1]};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // keep the trial difference when it does not borrow
         if (!diff[Width]) begin
            rem_in = diff[Width-1:0];
            quo_in = {quo_ff[Width-2:0], 1'b1};
         end else begin
            rem_in = shifted[Width-1:0];
            quo_in = {quo_ff[Width-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == LastCnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/step_dir_pulse_generator_unit.sv =====
// Top level of the step/dir pulse generator: sequencer, scheduler state and output register.
//
// Each request is one microsecond tick carrying enable, direction and a Q20.4 speed in
// steps per second; each request yields exactly one response with the step line level,
// the direction line (1 forward), a step-completed flag on the falling step edge and a
// wrapping signed position (reverse counts up). A tick passes through the idle, direction,
// schedule and emit states to a loaded response register when the speed is unchanged; a
// tick that changes the speed to a nonzero value also runs the radix-2 divider for
// floor(16000000 / speed), one quotient bit per cycle, in a divide state before scheduling.
// The block holds req_chan.ready low while a tick is in progress and takes the next request
// as soon as the response is loaded, even if it has not yet been taken. Configuration writes
// (pulse_high_us at index 0, dir_setup_us at index 1) are applied at once and belong between
// ticks. Time runs modulo 2^TimeBits; an edge is due once the current time is at or past it
// by less than half the time range.
module step_dir_pulse_generator_unit #(
   parameter int TimeBits = sdpg_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   sdpg_req_if.sink                          req_chan,
   sdpg_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [sdpg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sdpg_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int SpW   = sdpg_pkg::SPEED_W;
   localparam int CfW   = sdpg_pkg::CFG_W;
   localparam int PosW  = sdpg_pkg::POS_W;
   localparam int WideW = (TimeBits > SpW) ? TimeBits : SpW;

   sdpg_pkg::state_type state_ff, state_in;

   // configuration
   logic [CfW-1:0]      pulse_high_ff, pulse_high_in;
   logic [CfW-1:0]      dir_setup_ff, dir_setup_in;

   // latched request
   logic                en_ff, en_in;
   logic                dir_ff, dir_in;
   logic [SpW-1:0]      speed_ff, speed_in;

   // scheduler state
   logic [TimeBits-1:0] now_ff, now_in;
   logic [TimeBits-1:0] due_ff, due_in;
   logic                pulse_hi_ff, pulse_hi_in;
   logic                run_ff, run_in;
   logic                cur_dir_ff, cur_dir_in;
   logic [SpW-1:0]      interval_ff, interval_in;
   logic [SpW-1:0]      last_speed_ff, last_speed_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic                done_ff, done_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_step_ff, rsp_step_in;
   logic                rsp_dir_ff, rsp_dir_in;
   logic                rsp_done_ff, rsp_done_in;
   logic [PosW-1:0]     rsp_pos_ff, rsp_pos_in;

   // divider
   logic                div_start;
   logic                div_done;
   logic [SpW-1:0]      div_quo;

   // scheduler arithmetic
   logic [TimeBits-1:0] guard_time;
   logic [TimeBits-1:0] guard_gap;
   logic [TimeBits-1:0] now_gap;
   logic                edge_due;
   logic [SpW-1:0]      low_wait;
   logic [WideW-1:0]    low_sum;
   logic [TimeBits-1:0] high_end;

   logic                req_fire;

   assign req_fire = req_chan.valid && req_chan.ready;

   sdpg_divider #(
      .Width (SpW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sdpg_pkg::INTERVAL_NUM),
      .divisor  (speed_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      guard_time = now_ff + TimeBits'(dir_setup_ff);
      guard_gap  = guard_time - due_ff;
      now_gap    = now_ff - due_ff;
      edge_due   = !now_gap[TimeBits-1];
      // low phase saturates at zero when the interval is shorter than the pulse
      low_wait   = (interval_ff > SpW'(pulse_high_ff)) ? interval_ff - SpW'(pulse_high_ff) : '0;
      low_sum    = WideW'(now_ff) + WideW'(low_wait);
      high_end   = now_ff + TimeBits'(pulse_high_ff);
   end

   always_comb begin
      state_in      = state_ff;
      pulse_high_in = pulse_high_ff;
      dir_setup_in  = dir_setup_ff;
      en_in         = en_ff;
      dir_in        = dir_ff;
      speed_in      = speed_ff;
      now_in        = now_ff;
      due_in        = due_ff;
      pulse_hi_in   = pulse_hi_ff;
      run_in        = run_ff;
      cur_dir_in    = cur_dir_ff;
      interval_in   = interval_ff;
      last_speed_in = last_speed_ff;
      pos_in        = pos_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_step_in   = rsp_step_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_pos_in    = rsp_pos_ff;
      div_start     = 1'b0;
      req_chan.ready = 1'b0;

      if (csr_we) begin
         unique case (sdpg_pkg::csr_index_type'(csr_index))
            sdpg_pkg::REG_PULSE_HIGH: pulse_high_in = csr_wdata;
            sdpg_pkg::REG_DIR_SETUP:  dir_setup_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         sdpg_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               en_in    = req_chan.enable_in;
               dir_in   = req_chan.direction_in;
               speed_in = req_chan.speed_q4;
               state_in = sdpg_pkg::ST_DIR;
            end
         end
         sdpg_pkg::ST_DIR: begin
            // apply enable and direction, then decide whether a new interval is needed
            run_in = en_ff;
            if (!en_ff) begin
               pulse_hi_in = 1'b0;
            end
            if (dir_ff != cur_dir_ff) begin
               cur_dir_in = dir_ff;
               if (guard_time != due_ff && !guard_gap[TimeBits-1]) begin
                  due_in = guard_time;
               end
            end
            state_in = sdpg_pkg::ST_SCHED;
            if (speed_ff != last_speed_ff) begin
               last_speed_in = speed_ff;
               if (speed_ff == '0) begin
                  interval_in = '0;
               end else begin
                  div_start = 1'b1;
                  state_in  = sdpg_pkg::ST_DIV;
               end
            end
         end
         sdpg_pkg::ST_DIV: begin
            if (div_done) begin
               interval_in = (div_quo == '0) ? SpW'(1) : div_quo;
               state_in    = sdpg_pkg::ST_SCHED;
            end
         end
         sdpg_pkg::ST_SCHED: begin
            done_in = 1'b0;
            if (run_ff && interval_ff != '0 && edge_due) begin
               if (!pulse_hi_ff) begin
                  pulse_hi_in = 1'b1;
                  due_in      = high_end;
               end else begin
                  pulse_hi_in = 1'b0;
                  done_in     = 1'b1;
                  pos_in      = cur_dir_ff ? pos_ff + PosW'(1) : pos_ff - PosW'(1);
                  due_in      = low_sum[TimeBits-1:0];
               end
            end
            now_in   = now_ff + TimeBits'(1);
            state_in = sdpg_pkg::ST_EMIT;
         end
         sdpg_pkg::ST_EMIT: begin
            // load the response once the previous one has been taken
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_step_in  = pulse_hi_ff;
               rsp_dir_in   = !cur_dir_ff;
               rsp_done_in  = done_ff;
               rsp_pos_in   = pos_ff;
               state_in     = sdpg_pkg::ST_IDLE;
            end
         end
         default: state_in = sdpg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_high_ff <= sdpg_pkg::PULSE_HIGH_RESET;
         dir_setup_ff  <= sdpg_pkg::DIR_SETUP_RESET;
         now_ff        <= '0;
         due_ff        <= '0;
         pulse_hi_ff   <= 1'b0;
         run_ff        <= 1'b1;
         cur_dir_ff    <= 1'b0;
         interval_ff   <= '0;
         last_speed_ff <= '0;
         pos_ff        <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pulse_high_ff <= pulse_high_in;
         dir_setup_ff  <= dir_setup_in;
         now_ff        <= now_in;
         due_ff        <= due_in;
         pulse_hi_ff   <= pulse_hi_in;
         run_ff        <= run_in;
         cur_dir_ff    <= cur_dir_in;
         interval_ff   <= interval_in;
         last_speed_ff <= last_speed_in;
         pos_ff        <= pos_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      en_ff       <= en_in;
      dir_ff      <= dir_in;
      speed_ff    <= speed_in;
      rsp_step_ff <= rsp_step_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_done_ff <= rsp_done_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.step_level = rsp_step_ff;
   assign rsp_chan.dir_level  = rsp_dir_ff;
   assign rsp_chan.step_done  = rsp_done_ff;
   assign rsp_chan.position   = rsp_pos_ff;

   // a tick blocks further requests until its response is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request accepted while a tick was in progress");

   // a completed step is always the falling edge of the step line
   a_done_is_falling: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.step_done |-> !rsp_chan.step_level)
      else $error("step_done reported with step line high");

   // the position moves only in the scheduling cycle of a completed step
   a_pos_only_on_step: assert property (@(posedge clock) disable iff (reset)
      pos_ff != $past(pos_ff) |-> $past(state_ff == sdpg_pkg::ST_SCHED) && done_ff)
      else $error("position moved outside a completed step");

   // the divider reports a quotient only while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == sdpg_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

endmodule

// ===== sim/sdpg_pulse_checker.sv =====
// Checker for the step/dir pulse generator: predicts each tick response and compares it.
module sdpg_pulse_checker (
   input  logic                           clock,
   input  logic                           reset,
   sdpg_req_if                            req_chan,
   sdpg_rsp_if                            rsp_chan,
   input  logic                           csr_we,
   input  logic [sdpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sdpg_pkg::CFG_W-1:0]     csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    outstanding
);

   localparam int SpeedW = sdpg_pkg::SPEED_W;
   localparam int CfgW   = sdpg_pkg::CFG_W;
   localparam int PosW   = sdpg_pkg::POS_W;
   // 1e6 us per second, scaled by 16 for the speed fraction bits
   localparam logic [31:0] STEPS_Q4_PER_US = 32'd16_000_000;

   typedef struct packed {
      logic                   step_level;
      logic                   dir_level;
      logic                   step_done;
      logic signed [PosW-1:0] position;
   } tick_sample_type;

   logic [CfgW-1:0]        pulse_width;
   logic [CfgW-1:0]        guard_width;
   logic [31:0]            now_us;
   logic [31:0]            edge_due;
   logic                   high_phase;
   logic                   dir_reverse;
   logic [SpeedW-1:0]      interval_us;
   logic [SpeedW-1:0]      held_speed;
   logic signed [PosW-1:0] step_count;
   tick_sample_type        expected_ticks[$];
   int unsigned            fail_tally = 0;

   // true when time a is at or after time b, modulo the time range
   function automatic logic at_or_after(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return !diff[31];
   endfunction

   function automatic tick_sample_type predict_tick(input logic en, input logic dir,
                                                    input logic [SpeedW-1:0] speed);
      tick_sample_type r;
      logic [31:0]     guard;
      logic [31:0]     low_wait;
      logic [31:0]     quotient;
      r.step_done = 1'b0;
      if (!en)
         high_phase = 1'b0;
      if (dir != dir_reverse) begin
         guard = now_us + 32'(guard_width);
         dir_reverse = dir;
         if (guard != edge_due && at_or_after(guard, edge_due))
            edge_due = guard;
      end
      if (speed != held_speed) begin
         held_speed = speed;
         if (speed == '0) begin
            interval_us = '0;
         end else begin
            quotient = STEPS_Q4_PER_US / {8'd0, speed};
            interval_us = (quotient == 0) ? SpeedW'(1) : quotient[SpeedW-1:0];
         end
      end
      if (en && interval_us != '0 && at_or_after(now_us, edge_due)) begin
         if (!high_phase) begin
            high_phase = 1'b1;
            edge_due = now_us + 32'(pulse_width);
         end else begin
            high_phase = 1'b0;
            r.step_done = 1'b1;
            step_count = dir_reverse ? step_count + 1 : step_count - 1;
            // low wait saturates when the interval is shorter than the pulse
            low_wait = (interval_us > SpeedW'(pulse_width))
                          ? 32'(interval_us - SpeedW'(pulse_width)) : 32'd0;
            edge_due = now_us + low_wait;
         end
      end
      now_us = now_us + 1;
      r.step_level = high_phase;
      r.dir_level = !dir_reverse;
      r.position = step_count;
      return r;
   endfunction

   task automatic flag_field(input string field, input logic signed [PosW-1:0] want_v,
                             input logic signed [PosW-1:0] seen_v);
      fail_tally++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, seen_v);
   endtask

   always @(posedge clock) begin
      tick_sample_type seen;
      tick_sample_type want;
      if (reset) begin
         pulse_width = sdpg_pkg::PULSE_HIGH_RESET;
         guard_width = sdpg_pkg::DIR_SETUP_RESET;
         now_us = '0;
         edge_due = '0;
         high_phase = 1'b0;
         dir_reverse = 1'b0;
         interval_us = '0;
         held_speed = '0;
         step_count = '0;
         expected_ticks.delete();
      end else begin
         if (csr_we) begin
            case (sdpg_pkg::csr_index_type'(csr_index))
               sdpg_pkg::REG_PULSE_HIGH: pulse_width = csr_wdata;
               sdpg_pkg::REG_DIR_SETUP:  guard_width = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = '{rsp_chan.step_level, rsp_chan.dir_level, rsp_chan.step_done,
                     rsp_chan.position};
            if (expected_ticks.size() == 0) begin
               fail_tally++;
               $display("%0t: response with no request outstanding, expected none, got %0d",
                        $time, seen.position);
            end else begin
               want = expected_ticks.pop_front();
               if (seen.step_level !== want.step_level)
                  flag_field("step_level", PosW'(want.step_level), PosW'(seen.step_level));
               if (seen.dir_level !== want.dir_level)
                  flag_field("dir_level", PosW'(want.dir_level), PosW'(seen.dir_level));
               if (seen.step_done !== want.step_done)
                  flag_field("step_done", PosW'(want.step_done), PosW'(seen.step_done));
               if (seen.position !== want.position)
                  flag_field("position", want.position, seen.position);
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_ticks.push_back(predict_tick(req_chan.enable_in, req_chan.direction_in,
                                                  req_chan.speed_q4));
      end
      mismatches <= fail_tally;
      outstanding <= expected_ticks.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the step/dir pulse generator: stimulus, back-pressure and verdict.
module tb;

   localparam int SpeedW  = sdpg_pkg::SPEED_W;
   localparam int CfgW    = sdpg_pkg::CFG_W;
   localparam int CsrIdxW = sdpg_pkg::CSR_IDX_W;

   localparam int unsigned RESET_CYCLES     = 8;
   localparam int unsigned DRAIN_CYCLES     = 64;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned PHASES           = 7;
   localparam int unsigned PHASE_REQUESTS   = 110;
   localparam int unsigned RUN_LIMIT        = 2_000_000;
   // speed that gives an interval of exactly one microsecond
   localparam logic [SpeedW-1:0] ONE_STEP_PER_US = 24'd16_000_000;
   localparam logic [SpeedW-1:0] SPEED_MAX       = '1;

   // register settings per phase; the last phase draws its own
   localparam logic [CfgW-1:0] PULSE_TABLE [PHASES] = '{10'd1, 10'd0, 10'd1023, 10'd3,
                                                        10'd1000, 10'd7, 10'd2};
   localparam logic [CfgW-1:0] GUARD_TABLE [PHASES] = '{10'd0, 10'd1023, 10'd1000, 10'd17,
                                                        10'd0, 10'd2, 10'd5};

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CsrIdxW-1:0]   csr_index;
   logic [CfgW-1:0]      csr_wdata;
   int unsigned          mismatches;
   int unsigned          outstanding;

   int unsigned          offered = 0;     // requests accepted so far
   int unsigned          burst_left = 0;  // requests left in the current sender burst
   bit                   sender_eager = 1'b0;
   int unsigned          hold_asks = 0;   // long receiver hold-offs requested

   sdpg_req_if req_bus ();
   sdpg_rsp_if rsp_bus ();

   step_dir_pulse_generator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sdpg_pulse_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one tick request and hold it until the block takes it. Open a new burst
   // when the old one is used up, idling the request channel for a random gap first
   // unless the sender runs eager.
   task automatic offer_tick(input logic en, input logic dir, input logic [SpeedW-1:0] speed);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (!sender_eager) begin
            gap = $urandom_range(1, 12);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.enable_in <= en;
      req_bus.direction_in <= dir;
      req_bus.speed_q4 <= speed;
      do @(posedge clock); while (!req_bus.ready);
      offered++;
   endtask

   task automatic run_ticks(input logic en, input logic dir, input logic [SpeedW-1:0] speed,
                            input int unsigned count);
      repeat (count) offer_tick(en, dir, speed);
   endtask

   // Drop valid, wait for every response to come back, then idle for a further drain
   // period so that nothing is in flight.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Load both timing registers on back-to-back cycles while idle.
   task automatic load_timing(input logic [CfgW-1:0] pulse, input logic [CfgW-1:0] guard);
      csr_we <= 1'b1;
      csr_index <= sdpg_pkg::REG_PULSE_HIGH;
      csr_wdata <= pulse;
      @(posedge clock);
      csr_index <= sdpg_pkg::REG_DIR_SETUP;
      csr_wdata <= guard;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Well-formed motion: hold one speed for a run of ticks so that pulses actually
   // form, with the odd direction reversal and the odd disabled tick mixed in.
   task automatic motion_run();
      int unsigned        period;
      int unsigned        len;
      logic               dir;
      logic               en;
      logic [SpeedW-1:0]  speed;
      period = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 24);
      speed = SpeedW'(ONE_STEP_PER_US / period + $urandom_range(0, 3));
      len = $urandom_range(4, 32);
      dir = 1'($urandom_range(0, 1));
      repeat (len) begin
         if ($urandom_range(0, 11) == 0)
            dir = !dir;
         en = ($urandom_range(0, 19) != 0);
         offer_tick(en, dir, speed);
      end
   endtask

   // Noise: short bursts of arbitrary fields, including stops and out-of-range speeds.
   task automatic noise_burst();
      logic [SpeedW-1:0] speed;
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(0, 3))
            0:       speed = '0;
            1:       speed = SpeedW'($urandom_range(ONE_STEP_PER_US, SPEED_MAX));
            default: speed = SpeedW'($urandom());
         endcase
         offer_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), speed);
      end
   endtask

   // Response side: pace ready by a mode that is redrawn whenever its random hold count runs out, and
   // serve each long hold-off request by keeping ready low for a counted stretch.
   initial begin : rsp_pacing
      int unsigned mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned holds_served;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      holds_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (holds_served != hold_asks) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 128);
            end else begin
               mode_left--;
            end
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= mode_left[2];
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned      phase;
      int unsigned      phase_start;
      bit               hold_asked;
      logic [CfgW-1:0]  pulse;
      logic [CfgW-1:0]  guard;

      // drive every input to a known value and hold reset
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= sdpg_pkg::REG_PULSE_HIGH;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.enable_in <= 1'b0;
      req_bus.direction_in <= 1'b0;
      req_bus.speed_q4 <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks under the reset timing (pulse 2 us, guard 5 us).
      run_ticks(1'b1, 1'b0, '0, 2);               // stopped from reset
      run_ticks(1'b1, 1'b0, ONE_STEP_PER_US, 5);  // interval below pulse width: low wait is zero
      run_ticks(1'b1, 1'b1, ONE_STEP_PER_US, 3);  // reversal pushes the next edge by the guard
      run_ticks(1'b0, 1'b1, ONE_STEP_PER_US, 2);  // disable forces the step line low
      run_ticks(1'b1, 1'b1, SPEED_MAX, 3);        // quotient zero clamps to one
      run_ticks(1'b1, 1'b1, 24'd4_000_000, 2);
      run_ticks(1'b1, 1'b1, '0, 2);               // stop: a high pulse stays high
      run_ticks(1'b1, 1'b0, 24'd1, 2);            // slowest speed
      run_ticks(1'b1, 1'b0, 24'd5_333_333, 4);

      // Random phases, each with its own timing registers.
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         pulse = PULSE_TABLE[phase];
         guard = GUARD_TABLE[phase];
         if (phase == PHASES - 1) begin
            pulse = CfgW'($urandom_range(0, 15));
            guard = CfgW'($urandom_range(0, 1023));
         end
         load_timing(pulse, guard);
         sender_eager = (phase == 2 || phase == 5);
         hold_asked = 1'b0;
         phase_start = offered;
         while (offered - phase_start < PHASE_REQUESTS) begin
            // stall the receiver for a long stretch while the sender keeps offering
            if (sender_eager && !hold_asked && offered - phase_start >= 40) begin
               hold_asks <= hold_asks + 1;
               hold_asked = 1'b1;
            end
            if ($urandom_range(0, 4) != 0)
               motion_run();
            else
               noise_burst();
         end
      end

      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/sdpg_pkg.sv
rtl/core/sdpg_ifs.sv
rtl/core/sdpg_divider.sv
rtl/core/step_dir_pulse_generator_unit.sv
sim/sdpg_pulse_checker.sv
sim/tb.sv
